FILE: src/qru_pkg.sv
// Shared types, codes and constants of the quaternion rotation unit.
`default_nettype none

package qru_pkg;

    localparam int FRAC_BITS_DEF    = 14;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int IN_W   = 88;
    localparam int OUT_W  = 104;
    localparam int N2_W   = 33;
    localparam int SQ_W   = 50;
    localparam int IDX_W  = 6;

    localparam logic signed [33:0] GAIN_Q30     = 34'sd652032874;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;

    localparam logic [1:0] OP_AXIS_ANGLE = 2'd0;
    localparam logic [1:0] OP_LOAD       = 2'd1;
    localparam logic [1:0] OP_NORMALIZE  = 2'd2;
    localparam logic [1:0] OP_MATRIX     = 2'd3;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CORDIC_STEP,
        CMD_CORDIC_DONE,
        CMD_AXMUL,
        CMD_SQ,
        CMD_SQRT_INIT,
        CMD_SQRT_STEP,
        CMD_SCALE_DONE,
        CMD_NORM_DONE,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_DIV_DONE,
        CMD_MAT,
        CMD_EMIT_QUAT,
        CMD_EMIT_ROW
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t          cmd;
        logic [IDX_W-1:0] idx;
        logic             scale;
    } dp_ctrl_t;

    typedef struct packed {
        logic n2_zero;
    } dp_stat_t;

    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            5'd30:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: src/qru_ctrl.sv
// Sequencing state machine of the quaternion rotation unit.
`default_nettype none

module qru_ctrl #(
    parameter int FRAC_BITS    = qru_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = qru_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [1:0]         in_op,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output qru_pkg::dp_ctrl_t       ctrl,
    input  wire qru_pkg::dp_stat_t  stat
);

    localparam int STEPS      = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int QB         = FRAC_BITS + 3;
    localparam int ROOT_STEPS = qru_pkg::SQ_W / 2;
    localparam int IW         = qru_pkg::IDX_W;

    typedef enum logic [4:0] {
        IDLE, CORDIC, CORDIC_END, AXMUL, SCALE_SQ, SCALE_CHK, SCALE_SQRT,
        SCALE_END, DIV_INIT, DIV, DIV_END, NORM_SQ, NORM_INIT, NORM_SQRT,
        NORM_END, MATMUL, EMIT, HOLD
    } state_t;

    state_t         state_reg, state_next;
    logic [IW-1:0]  cnt_reg, cnt_next;
    logic [1:0]     comp_reg, comp_next;
    logic [1:0]     op_reg, op_next;
    logic           valid_reg, valid_next;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        op_next    = op_reg;
        valid_next = valid_reg;
        ctrl.cmd   = qru_pkg::CMD_NONE;
        ctrl.idx   = cnt_reg;
        ctrl.scale = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.cmd  = qru_pkg::CMD_LOAD;
                    op_next   = in_op;
                    cnt_next  = '0;
                    comp_next = '0;
                    case (in_op)
                        qru_pkg::OP_AXIS_ANGLE: state_next = CORDIC;
                        qru_pkg::OP_NORMALIZE:  state_next = SCALE_SQ;
                        default:                state_next = NORM_SQ;
                    endcase
                end
            end
            CORDIC:
            begin
                ctrl.cmd = qru_pkg::CMD_CORDIC_STEP;
                if (cnt_reg == IW'(STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = CORDIC_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            CORDIC_END:
            begin
                ctrl.cmd   = qru_pkg::CMD_CORDIC_DONE;
                state_next = AXMUL;
            end
            AXMUL:
            begin
                ctrl.cmd = qru_pkg::CMD_AXMUL;
                if (cnt_reg == IW'(3))
                begin
                    cnt_next   = '0;
                    state_next = NORM_SQ;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            SCALE_SQ:
            begin
                ctrl.cmd = qru_pkg::CMD_SQ;
                if (cnt_reg == IW'(4))
                begin
                    cnt_next   = '0;
                    state_next = SCALE_CHK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            SCALE_CHK:
            begin
                if (stat.n2_zero)
                begin
                    state_next = NORM_SQ;
                end
                else
                begin
                    ctrl.cmd   = qru_pkg::CMD_SQRT_INIT;
                    ctrl.scale = 1'b1;
                    state_next = SCALE_SQRT;
                end
            end
            SCALE_SQRT:
            begin
                ctrl.cmd = qru_pkg::CMD_SQRT_STEP;
                if (cnt_reg == IW'(ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = SCALE_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            SCALE_END:
            begin
                ctrl.cmd   = qru_pkg::CMD_SCALE_DONE;
                comp_next  = '0;
                state_next = DIV_INIT;
            end
            DIV_INIT:
            begin
                ctrl.cmd   = qru_pkg::CMD_DIV_INIT;
                ctrl.idx   = IW'(comp_reg);
                cnt_next   = '0;
                state_next = DIV;
            end
            DIV:
            begin
                ctrl.cmd = qru_pkg::CMD_DIV_STEP;
                if (cnt_reg == IW'(QB - 1))
                begin
                    cnt_next   = '0;
                    state_next = DIV_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            DIV_END:
            begin
                ctrl.cmd = qru_pkg::CMD_DIV_DONE;
                ctrl.idx = IW'(comp_reg);
                if (comp_reg == 2'd3)
                begin
                    comp_next  = '0;
                    state_next = NORM_SQ;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = DIV_INIT;
                end
            end
            NORM_SQ:
            begin
                ctrl.cmd = qru_pkg::CMD_SQ;
                if (cnt_reg == IW'(4))
                begin
                    cnt_next   = '0;
                    state_next = NORM_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            NORM_INIT:
            begin
                ctrl.cmd   = qru_pkg::CMD_SQRT_INIT;
                state_next = NORM_SQRT;
            end
            NORM_SQRT:
            begin
                ctrl.cmd = qru_pkg::CMD_SQRT_STEP;
                if (cnt_reg == IW'(ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = NORM_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            NORM_END:
            begin
                ctrl.cmd   = qru_pkg::CMD_NORM_DONE;
                state_next = (op_reg == qru_pkg::OP_MATRIX) ? MATMUL : EMIT;
            end
            MATMUL:
            begin
                ctrl.cmd = qru_pkg::CMD_MAT;
                if (cnt_reg == IW'(9))
                begin
                    cnt_next   = '0;
                    comp_next  = '0;
                    state_next = EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            EMIT:
            begin
                ctrl.cmd   = (op_reg == qru_pkg::OP_MATRIX) ? qru_pkg::CMD_EMIT_ROW
                                                            : qru_pkg::CMD_EMIT_QUAT;
                ctrl.idx   = IW'(comp_reg);
                valid_next = 1'b1;
                state_next = HOLD;
            end
            HOLD:
            begin
                if (m_tready)
                begin
                    valid_next = 1'b0;
                    if ((op_reg == qru_pkg::OP_MATRIX) && (comp_reg != 2'd2))
                    begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = EMIT;
                    end
                    else
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            op_reg    <= qru_pkg::OP_AXIS_ANGLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            op_reg    <= op_next;
            valid_reg <= valid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !s_tready)
        else $error("input accepted while a result is pending");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != IDLE))
        else $error("accepted request did not start work");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == HOLD && !m_tready) |=> (state_reg == HOLD && valid_reg))
        else $error("result dropped while receiver stalled");
`endif

endmodule

`default_nettype wire

FILE: src/qru_dp.sv
// Datapath of the quaternion rotation unit: CORDIC, multiplier, square root and divider.
`default_nettype none

module qru_dp #(
    parameter int FRAC_BITS = qru_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire qru_pkg::dp_ctrl_t         ctrl,
    input  wire logic [qru_pkg::IN_W-1:0]  in_data,
    output qru_pkg::dp_stat_t              stat,
    output logic [19:0]                    out_a,
    output logic [19:0]                    out_b,
    output logic [19:0]                    out_c,
    output logic [19:0]                    out_d,
    output logic [16:0]                    norm_value,
    output logic                           last
);

    localparam int F    = FRAC_BITS;
    localparam int MB   = (F + 2 > 16) ? F + 2 : 16;
    localparam int PW   = 16 + MB;
    localparam int MW   = ((PW > 2 * F + 1) ? PW : 2 * F + 1) + 3;
    localparam int CSH  = 30 - F;
    localparam int QB   = F + 3;
    localparam int RTW  = qru_pkg::SQ_W / 2;
    localparam int RMW  = RTW + 2;
    localparam int DVW  = RTW + 1;
    localparam int DRW  = DVW + 1;
    localparam int DW   = F + 27;
    localparam int N2W  = qru_pkg::N2_W;
    localparam int LW0  = (PW > QB + 2) ? PW : QB + 2;
    localparam int LW   = (LW0 > 35) ? LW0 : 35;

    localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (F - 1);
    localparam logic signed [MW-1:0] HALF_M = MW'(1) <<< (F - 1);
    localparam logic signed [MW-1:0] ONE_M  = MW'(1) <<< (2 * F);
    localparam logic signed [33:0]   HALF_C = (34'sd1 <<< CSH) >>> 1;

    function automatic logic [15:0] sat16(input logic signed [LW-1:0] v);
        logic [15:0] r;
        if (v > 32767)
            r = 16'h7FFF;
        else if (v < -32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [19:0] mat_entry(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] t;
        logic [19:0]          r;
        t = (v + HALF_M) >>> F;
        if (t > 524287)
            r = 20'h7FFFF;
        else if (t < -524288)
            r = 20'h80000;
        else
            r = t[19:0];
        return r;
    endfunction

    logic signed [15:0]   qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [15:0]   ax_reg, ay_reg, az_reg;
    logic signed [33:0]   cx_reg, cy_reg, cz_reg;
    logic signed [MB-1:0] sn_reg;
    logic [15:0]          cs_reg;
    logic signed [PW-1:0] prod_reg;
    logic [N2W-1:0]       n2_reg;
    logic [qru_pkg::SQ_W-1:0] rad_reg;
    logic [RMW-1:0]       rem_reg;
    logic [RTW-1:0]       root_reg;
    logic [RTW-1:0]       s_reg;
    logic [16:0]          norm_reg;
    logic [DRW-1:0]       drem_reg;
    logic [QB-1:0]        dlow_reg;
    logic [QB-1:0]        dquo_reg;
    logic                 dneg_reg;
    logic signed [PW-1:0] p_reg [9];

    logic signed [15:0]   mul_a;
    logic signed [MB-1:0] mul_b;
    logic [3:0]           prev;
    logic signed [15:0]   sel_q;
    logic [15:0]          ax_res;
    logic [N2W-1:0]       sq_term;
    logic [RMW+1:0]       sq_try;
    logic [RMW+1:0]       sq_trial;
    logic [RTW:0]         norm_sum;
    logic [16:0]          dmag;
    logic [DW-1:0]        dividend;
    logic [DRW:0]         dv_try;
    logic [DRW:0]         dv_div;
    logic signed [QB:0]   dq_signed;
    logic signed [33:0]   dx, dy, at;
    logic signed [33:0]   sn_full, cs_full;
    logic signed [MW-1:0] xx, yy, zz, xy, zx, yz, xs, ys, zs;
    logic [19:0]          e0, e1, e2;

    assign prev         = ctrl.idx[3:0] - 4'd1;
    assign stat.n2_zero = (n2_reg == '0);

    always_comb
    begin
        case (ctrl.idx[1:0])
            2'd0:    sel_q = qx_reg;
            2'd1:    sel_q = qy_reg;
            2'd2:    sel_q = qz_reg;
            default: sel_q = qw_reg;
        endcase
    end

    always_comb
    begin
        mul_a = qx_reg;
        mul_b = MB'(qx_reg);
        case (ctrl.cmd)
            qru_pkg::CMD_SQ:
            begin
                mul_a = sel_q;
                mul_b = MB'(sel_q);
            end
            qru_pkg::CMD_AXMUL:
            begin
                case (ctrl.idx[1:0])
                    2'd0:    mul_a = ax_reg;
                    2'd1:    mul_a = ay_reg;
                    default: mul_a = az_reg;
                endcase
                mul_b = sn_reg;
            end
            qru_pkg::CMD_MAT:
            begin
                case (ctrl.idx[3:0])
                    4'd0:    begin mul_a = qx_reg; mul_b = MB'(qx_reg); end
                    4'd1:    begin mul_a = qy_reg; mul_b = MB'(qy_reg); end
                    4'd2:    begin mul_a = qz_reg; mul_b = MB'(qz_reg); end
                    4'd3:    begin mul_a = qx_reg; mul_b = MB'(qy_reg); end
                    4'd4:    begin mul_a = qz_reg; mul_b = MB'(qx_reg); end
                    4'd5:    begin mul_a = qy_reg; mul_b = MB'(qz_reg); end
                    4'd6:    begin mul_a = qx_reg; mul_b = MB'(qw_reg); end
                    4'd7:    begin mul_a = qy_reg; mul_b = MB'(qw_reg); end
                    default: begin mul_a = qz_reg; mul_b = MB'(qw_reg); end
                endcase
            end
            default:
            begin
                mul_a = qx_reg;
                mul_b = MB'(qx_reg);
            end
        endcase
    end

    assign ax_res  = sat16(LW'((prod_reg + HALF_P) >>> F));
    assign sq_term = N2W'($unsigned(prod_reg));

    assign dx = cy_reg >>> ctrl.idx[4:0];
    assign dy = cx_reg >>> ctrl.idx[4:0];
    assign at = $signed(34'(qru_pkg::atan_turn(ctrl.idx[4:0])));
    assign sn_full = (cx_reg + HALF_C) >>> CSH;
    assign cs_full = (HALF_C - cy_reg) >>> CSH;

    assign sq_try   = {rem_reg, rad_reg[qru_pkg::SQ_W-1 -: 2]};
    assign sq_trial = (RMW + 2)'({root_reg, 2'b01});
    assign norm_sum = (RTW + 1)'(root_reg) + (RTW + 1)'(rem_reg > RMW'(root_reg));

    assign dmag     = sel_q[15] ? (17'd0 - 17'(sel_q)) : 17'(sel_q);
    assign dividend = (DW'(dmag) << (F + 9)) + DW'(s_reg);
    assign dv_try   = {drem_reg, dlow_reg[QB-1]};
    assign dv_div   = (DRW + 1)'({s_reg, 1'b0});
    assign dq_signed = dneg_reg ? -$signed({1'b0, dquo_reg}) : $signed({1'b0, dquo_reg});

    assign xx = MW'(p_reg[0]);
    assign yy = MW'(p_reg[1]);
    assign zz = MW'(p_reg[2]);
    assign xy = MW'(p_reg[3]);
    assign zx = MW'(p_reg[4]);
    assign yz = MW'(p_reg[5]);
    assign xs = MW'(p_reg[6]);
    assign ys = MW'(p_reg[7]);
    assign zs = MW'(p_reg[8]);

    always_comb
    begin
        case (ctrl.idx[1:0])
            2'd0:
            begin
                e0 = mat_entry(ONE_M - ((yy + zz) <<< 1));
                e1 = mat_entry((xy - zs) <<< 1);
                e2 = mat_entry((zx + ys) <<< 1);
            end
            2'd1:
            begin
                e0 = mat_entry((xy + zs) <<< 1);
                e1 = mat_entry(ONE_M - ((zz + xx) <<< 1));
                e2 = mat_entry((yz - xs) <<< 1);
            end
            default:
            begin
                e0 = mat_entry((zx - ys) <<< 1);
                e1 = mat_entry((yz + xs) <<< 1);
                e2 = mat_entry(ONE_M - ((yy + xx) <<< 1));
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            qw_reg <= '0;
        end
        else
        begin
            case (ctrl.cmd)
                qru_pkg::CMD_LOAD:
                begin
                    if (in_data[1:0] == qru_pkg::OP_LOAD)
                    begin
                        qx_reg <= in_data[17:2];
                        qy_reg <= in_data[33:18];
                        qz_reg <= in_data[49:34];
                        qw_reg <= in_data[65:50];
                    end
                end
                qru_pkg::CMD_AXMUL:
                begin
                    case (prev[1:0])
                        2'd0:
                        begin
                            qx_reg <= ax_res;
                            qw_reg <= cs_reg;
                        end
                        2'd1:    qy_reg <= ax_res;
                        2'd2:    qz_reg <= ax_res;
                        default: ;
                    endcase
                end
                qru_pkg::CMD_DIV_DONE:
                begin
                    case (ctrl.idx[1:0])
                        2'd0:    qx_reg <= sat16(LW'(dq_signed));
                        2'd1:    qy_reg <= sat16(LW'(dq_signed));
                        2'd2:    qz_reg <= sat16(LW'(dq_signed));
                        default: qw_reg <= sat16(LW'(dq_signed));
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
        case (ctrl.cmd)
            qru_pkg::CMD_LOAD:
            begin
                ax_reg <= in_data[17:2];
                ay_reg <= in_data[33:18];
                az_reg <= in_data[49:34];
                cx_reg <= qru_pkg::GAIN_Q30;
                cy_reg <= '0;
                cz_reg <= $signed({3'b000, in_data[81:66], 15'd0}) - qru_pkg::QUARTER_TURN;
            end
            qru_pkg::CMD_CORDIC_STEP:
            begin
                if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + at;
                end
            end
            qru_pkg::CMD_CORDIC_DONE:
            begin
                sn_reg <= MB'(sn_full);
                cs_reg <= sat16(LW'(cs_full));
            end
            qru_pkg::CMD_SQ:
            begin
                if (ctrl.idx[3:0] != 4'd0)
                begin
                    n2_reg <= (prev == 4'd0) ? sq_term : n2_reg + sq_term;
                end
            end
            qru_pkg::CMD_MAT:
            begin
                if (ctrl.idx[3:0] != 4'd0)
                begin
                    p_reg[prev] <= prod_reg;
                end
            end
            qru_pkg::CMD_SQRT_INIT:
            begin
                rad_reg  <= ctrl.scale ? qru_pkg::SQ_W'({n2_reg, 16'd0})
                                       : qru_pkg::SQ_W'(n2_reg);
                rem_reg  <= '0;
                root_reg <= '0;
            end
            qru_pkg::CMD_SQRT_STEP:
            begin
                rad_reg <= rad_reg << 2;
                if (sq_try >= sq_trial)
                begin
                    rem_reg  <= RMW'(sq_try - sq_trial);
                    root_reg <= {root_reg[RTW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= RMW'(sq_try);
                    root_reg <= {root_reg[RTW-2:0], 1'b0};
                end
            end
            qru_pkg::CMD_SCALE_DONE:
            begin
                s_reg <= root_reg;
            end
            qru_pkg::CMD_NORM_DONE:
            begin
                norm_reg <= (norm_sum > (RTW + 1)'(131071)) ? 17'h1FFFF : 17'(norm_sum);
            end
            qru_pkg::CMD_DIV_INIT:
            begin
                drem_reg <= DRW'(dividend >> QB);
                dlow_reg <= dividend[QB-1:0];
                dquo_reg <= '0;
                dneg_reg <= sel_q[15];
            end
            qru_pkg::CMD_DIV_STEP:
            begin
                dlow_reg <= dlow_reg << 1;
                if (dv_try >= dv_div)
                begin
                    drem_reg <= DRW'(dv_try - dv_div);
                    dquo_reg <= {dquo_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= DRW'(dv_try);
                    dquo_reg <= {dquo_reg[QB-2:0], 1'b0};
                end
            end
            qru_pkg::CMD_EMIT_QUAT:
            begin
                out_a      <= 20'(qx_reg);
                out_b      <= 20'(qy_reg);
                out_c      <= 20'(qz_reg);
                out_d      <= 20'(qw_reg);
                norm_value <= norm_reg;
                last       <= 1'b1;
            end
            qru_pkg::CMD_EMIT_ROW:
            begin
                out_a      <= e0;
                out_b      <= e1;
                out_c      <= e2;
                out_d      <= 20'(ctrl.idx[1:0]);
                norm_value <= norm_reg;
                last       <= (ctrl.idx[1:0] == 2'd2);
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/quaternion_rotation_unit.sv
// Top level of the quaternion rotation unit: controller and datapath with stream ports.
//
// One request on the slave stream carries an operation code and its operands.
// Axis-angle load, direct load and normalize each return one result holding
// the stored quaternion and its norm; the matrix operation returns three rows,
// the last marked with m_tlast. Rows carry the row index in out_d.
// Requests are handled one at a time; s_tready is high only while idle.
// The work is done by the bit-serial square root (25 steps, run once for
// the norm and once more for the normalize scale unless the quaternion is
// zero), by the CORDIC iterations, and by the shared divider, which takes
// FRAC_BITS + 3 steps per component.
// A result stays on the master stream until m_tready takes it; the next row or
// request waits meanwhile. Reset clears the quaternion to zero and empties the
// output stage.
`default_nettype none

module quaternion_rotation_unit #(
    parameter int FRAC_BITS    = qru_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = qru_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // operation, in_x, in_y, in_z, in_w, angle, zero fill
    input  wire logic [qru_pkg::IN_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // out_a, out_b, out_c, out_d, norm_value, zero fill
    output logic [qru_pkg::OUT_W-1:0]       m_tdata,
    output logic                            m_tlast
);

    qru_pkg::dp_ctrl_t ctrl;
    qru_pkg::dp_stat_t stat;
    logic [19:0]       out_a, out_b, out_c, out_d;
    logic [16:0]       norm_value;

    qru_ctrl #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (s_tdata[1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    qru_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_data    (s_tdata),
        .stat       (stat),
        .out_a      (out_a),
        .out_b      (out_b),
        .out_c      (out_c),
        .out_d      (out_d),
        .norm_value (norm_value),
        .last       (m_tlast)
    );

    assign m_tdata = {7'd0, norm_value, out_d, out_c, out_b, out_a};

endmodule

`default_nettype wire
